// ----- rtl/core/ctl_pkg.sv -----
`timescale 1ns / 1ps

package ctl_pkg;

    localparam int NAME_LIMIT_DEF  = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    // Result queue depth; a power of two so that the pointers wrap by themselves.
    localparam int OUT_DEPTH = 4;

    localparam logic [2:0] KIND_BAD   = 3'd0;
    localparam logic [2:0] KIND_INT   = 3'd1;
    localparam logic [2:0] KIND_NAME  = 3'd2;
    localparam logic [2:0] KIND_STR   = 3'd3;
    localparam logic [2:0] KIND_PUNCT = 3'd4;
    localparam logic [2:0] KIND_END   = 3'd5;

    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    typedef struct packed {
        logic [2:0]  kind;
        logic        is_char;
        logic [7:0]  char_out;
        logic [4:0]  position;
        logic [5:0]  length;
        logic [31:0] value;
        logic        last;
    } res_t;

    localparam res_t RES_ZERO = '0;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a))
            || (b == 8'h5f);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0d));
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        logic hit;
        case (b)
            8'h28, 8'h29, 8'h7b, 8'h7d, 8'h5b, 8'h5d, 8'h3b, 8'h3c,
            8'h3e, 8'h23, 8'h3d, 8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h2c: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ----- rtl/core/ctl_lex_core.sv -----
`timescale 1ns / 1ps

module ctl_lex_core #(
    parameter int NAME_LIMIT  = ctl_pkg::NAME_LIMIT_DEF,
    parameter int VALUE_WIDTH = ctl_pkg::VALUE_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    in_byte,
    input  logic          end_mark,
    output ctl_pkg::res_t res0,
    output ctl_pkg::res_t res1,
    output logic [1:0]    res_cnt
);

    import ctl_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_NAME,
        MODE_STR,
        MODE_LIT
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [5:0]             cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;

    res_t       c0, c1, c2;
    logic       c0v, c1v, c2v;
    logic       do_close, do_start, do_put;
    logic [2:0] put_kind;
    logic [5:0] base, nc;

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        c0 = RES_ZERO;
        c1 = RES_ZERO;
        c2 = RES_ZERO;
        c0v = 1'b0;
        c1v = 1'b0;
        c2v = 1'b0;
        do_close = 1'b0;
        do_start = 1'b0;
        do_put   = 1'b0;
        put_kind = KIND_NAME;
        base     = cnt_reg;
        nc       = '0;

        if (end_mark)
        begin
            do_close = 1'b1;
            c1v      = 1'b1;
            c1.kind  = KIND_END;
        end
        else
        begin
            unique case (mode_reg)
                MODE_INT:
                begin
                    if (is_digit(in_byte))
                        acc_next = (acc_reg << 3) + (acc_reg << 1)
                                 + VALUE_WIDTH'(in_byte[3:0]);
                    else
                    begin
                        do_close = 1'b1;
                        do_start = 1'b1;
                    end
                end
                MODE_NAME:
                begin
                    if (is_alpha(in_byte) || is_digit(in_byte))
                        do_put = 1'b1;
                    else
                    begin
                        do_close = 1'b1;
                        do_start = 1'b1;
                    end
                end
                MODE_STR:
                begin
                    if (in_byte == CH_DQUOTE)
                        do_close = 1'b1;
                    else
                    begin
                        do_put   = 1'b1;
                        put_kind = KIND_STR;
                    end
                end
                MODE_LIT:
                begin
                    if (in_byte == CH_SQUOTE)
                        do_close = 1'b1;
                    else
                        acc_next = (acc_reg << 8) + VALUE_WIDTH'(in_byte);
                end
                default:
                    do_start = 1'b1;
            endcase
        end

        if (do_close)
        begin
            unique case (mode_reg) inside
                MODE_INT, MODE_LIT:
                begin
                    c0v      = 1'b1;
                    c0.kind  = KIND_INT;
                    c0.value = 32'(acc_reg);
                end
                MODE_NAME, MODE_STR:
                begin
                    c0v       = 1'b1;
                    c0.kind   = (mode_reg == MODE_NAME) ? KIND_NAME : KIND_STR;
                    c0.length = cnt_reg;
                end
                default:
                    c0v = 1'b0;
            endcase
            mode_next = MODE_IDLE;
            cnt_next  = '0;
            acc_next  = '0;
        end

        if (do_start && !is_space(in_byte))
        begin
            if (is_digit(in_byte))
            begin
                mode_next = MODE_INT;
                acc_next  = VALUE_WIDTH'(in_byte[3:0]);
            end
            else if (is_alpha(in_byte))
            begin
                mode_next = MODE_NAME;
                do_put    = 1'b1;
                put_kind  = KIND_NAME;
                base      = '0;
            end
            else if (in_byte == CH_SQUOTE)
            begin
                mode_next = MODE_LIT;
                acc_next  = '0;
            end
            else if (in_byte == CH_DQUOTE)
            begin
                mode_next = MODE_STR;
                cnt_next  = '0;
            end
            else
            begin
                c1v         = 1'b1;
                c1.kind     = is_punct(in_byte) ? KIND_PUNCT : KIND_BAD;
                c1.char_out = in_byte;
            end
        end

        if (do_put)
        begin
            c1v         = 1'b1;
            c1.kind     = put_kind;
            c1.is_char  = 1'b1;
            c1.char_out = in_byte;
            c1.position = base[4:0];
            nc          = base + 6'd1;
            if (nc >= 6'(NAME_LIMIT))
            begin
                c2v       = 1'b1;
                c2.kind   = put_kind;
                c2.length = nc;
                mode_next = MODE_IDLE;
                cnt_next  = '0;
            end
            else
                cnt_next = nc;
        end
    end

    // A third candidate can only follow a completion, and at most two are kept.
    always_comb
    begin
        if (c0v)
        begin
            res0    = c0;
            res1    = c1;
            res_cnt = c1v ? 2'd2 : 2'd1;
        end
        else
        begin
            res0    = c1;
            res1    = c2;
            res_cnt = {1'b0, c1v} + {1'b0, c2v};
        end
        if (res_cnt == 2'd2)
            res1.last = 1'b1;
        else
            res0.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            cnt_reg  <= '0;
            acc_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

// ----- rtl/core/c_token_lexer.sv -----
`timescale 1ns / 1ps

// Byte-serial tokenizer for a small C-like language.
// The slave channel takes one source byte per item in s_tdata; an item with
// s_tlast high marks the end of input and its byte is ignored. The master
// channel gives zero, one or two result items per input item, and m_tlast
// is high on the final result caused by an input item.
// An accepted item is held in an input register until the queue has room for
// two results; its results are then written into a four-entry result queue,
// and m_tvalid is driven from the registered count of that queue.
// One input item is taken every cycle as long as the queue has room for two
// results; the output side drains one result per cycle while m_tready is high,
// which sets the sustained rate when most items produce results.
// When the receiver stalls, results wait in the queue, and s_tready drops
// once it can no longer hold two more.
// Reset empties the queue and the input register and leaves the lexer idle
// with no token open.
module c_token_lexer #(
    parameter int NAME_LIMIT  = ctl_pkg::NAME_LIMIT_DEF,
    parameter int VALUE_WIDTH = ctl_pkg::VALUE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tlast,   // end_mark
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // char_out, position, length, value, zero fill
    output logic [3:0]  m_tuser,   // kind, is_char
    output logic        m_tlast    // last
);

    import ctl_pkg::*;

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    logic             in_vld_reg;
    logic [7:0]       in_byte_reg;
    logic             in_end_reg;
    logic             proc;

    res_t             res0, res1;
    logic [1:0]       res_cnt;

    res_t             q_mem_reg [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] q_cnt_reg, q_cnt_next;
    logic             pop;
    res_t             head;

    assign proc     = in_vld_reg && (q_cnt_reg <= CNT_W'(OUT_DEPTH - 2));
    assign s_tready = !in_vld_reg || proc;
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tready)
            in_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    ctl_lex_core #(
        .NAME_LIMIT  (NAME_LIMIT),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (proc),
        .in_byte  (in_byte_reg),
        .end_mark (in_end_reg),
        .res0     (res0),
        .res1     (res1),
        .res_cnt  (res_cnt)
    );

    always_ff @(posedge clk)
    begin
        if (proc && (res_cnt != 2'd0))
            q_mem_reg[wr_ptr_reg] <= res0;
        if (proc && (res_cnt == 2'd2))
            q_mem_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
    end

    always_comb
    begin
        q_cnt_next = q_cnt_reg - CNT_W'(pop);
        if (proc)
            q_cnt_next = q_cnt_next + CNT_W'(res_cnt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            if (proc)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(res_cnt);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            q_cnt_reg <= q_cnt_next;
        end
    end

    assign head     = q_mem_reg[rd_ptr_reg];
    assign m_tvalid = (q_cnt_reg != '0);
    assign m_tdata  = {5'd0, head.value, head.length, head.position, head.char_out};
    assign m_tuser  = {head.is_char, head.kind};
    assign m_tlast  = head.last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= CNT_W'(OUT_DEPTH))
        else $error("result queue count exceeds its depth");

    a_char_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[3]) |-> (m_tuser[2:0] == KIND_NAME || m_tuser[2:0] == KIND_STR))
        else $error("character result with a kind other than name or string");

    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_end_reg) |->
            ((res_cnt == 2'd1 && res0.kind == KIND_END)
             || (res_cnt == 2'd2 && res1.kind == KIND_END)))
        else $error("end of input did not finish with an end result");

endmodule
